FILE: sv/dmcc_pkg.sv
package dmcc_pkg;

  localparam int FracBitsDef = 16;
  // Wide enough for 4*(p_i + p_j) and 3*den with exp2 values up to 2^58
  localparam int NW  = 66;
  localparam int XW  = 59;
  localparam int PCW = 24;

  localparam logic [XW-1:0] ExpCap = {XW{1'b1}} >> 1;

  typedef enum logic [1:0] {
    MT_COUNTS    = 2'd0,
    MT_PROB      = 2'd1,
    MT_LOG2ODDS  = 2'd2,
    MT_INFO      = 2'd3
  } matrix_e;

  typedef enum logic [1:0] {
    CFG_MATRIX_TYPE = 2'd0,
    CFG_RNA_MODE    = 2'd1,
    CFG_PSEUDOCOUNT = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    LTR_A = 4'd0,  LTR_C = 4'd1,  LTR_G = 4'd2,  LTR_T = 4'd3,
    LTR_U = 4'd4,  LTR_M = 4'd5,  LTR_R = 4'd6,  LTR_W = 4'd7,
    LTR_S = 4'd8,  LTR_Y = 4'd9,  LTR_K = 4'd10, LTR_H = 4'd11,
    LTR_B = 4'd12, LTR_V = 4'd13, LTR_D = 4'd14, LTR_N = 4'd15
  } letter_e;

  typedef struct packed {
    logic                 zero;
    logic [3:0][NW-1:0]   num;
    logic [NW-1:0]        den;
  } frac_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = '0;
    b   = 64'h4000_0000_0000_0000;
    rem = x;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Root factor for fraction bit of weight 2^-j, 30 fraction bits
  function automatic logic [63:0] exp_root(input int j);
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int k = 1; k <= j; k++) begin
      r = isqrt64(r << 30);
    end
    return r;
  endfunction

endpackage

FILE: sv/dmcc_exp_lane.sv
module dmcc_exp_lane #(
  parameter int FRAC_BITS = dmcc_pkg::FracBitsDef
) (
  input  logic                       clk_i,
  input  logic [FRAC_BITS+1:1]       en_i,
  input  logic signed [31:0]         value_i,
  output logic signed [31:0]         value_o,
  output logic [dmcc_pkg::XW-1:0]    exp_o
);
  import dmcc_pkg::*;

  logic signed [31:0] v_q [1:FRAC_BITS];
  logic [31:0]        m_q [1:FRAC_BITS];

  for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_step
    localparam logic [63:0] RootW = exp_root(j);
    localparam logic [31:0] Root  = RootW[31:0];
    logic [31:0]        m_prev;
    logic signed [31:0] v_prev;
    logic [63:0]        prod;

    if (j == 1) begin : g_first
      assign m_prev = 32'h4000_0000;
      assign v_prev = value_i;
    end else begin : g_next
      assign m_prev = m_q[j-1];
      assign v_prev = v_q[j-1];
    end

    // round half up after the 30-bit fraction product
    assign prod = {32'b0, m_prev} * {32'b0, Root} + 64'h2000_0000;

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        v_q[j] <= v_prev;
        m_q[j] <= v_prev[FRAC_BITS-j] ? prod[61:30] : m_prev;
      end
    end
  end

  logic signed [31:0] n_int;
  logic signed [33:0] sh;
  logic signed [33:0] nsh;
  logic [63:0]        up;
  logic [XW-1:0]      x_d;

  assign n_int = v_q[FRAC_BITS] >>> FRAC_BITS;
  assign sh    = 34'(n_int) + 34'(FRAC_BITS) - 34'sd30;
  assign nsh   = -sh;
  assign up    = {32'b0, m_q[FRAC_BITS]} << sh[4:0];

  always_comb begin
    if (sh >= 34'sd27) begin
      x_d = ExpCap;
    end else if (sh > 34'sd0) begin
      x_d = (up > 64'(ExpCap)) ? ExpCap : up[XW-1:0];
    end else if (nsh >= 34'sd63) begin
      x_d = '0;
    end else begin
      x_d = XW'(m_q[FRAC_BITS] >> nsh[5:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[FRAC_BITS+1]) begin
      value_o <= v_q[FRAC_BITS];
      exp_o   <= x_d;
    end
  end

endmodule

FILE: sv/dmcc_norm.sv
module dmcc_norm #(
  parameter int FRAC_BITS = dmcc_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  dmcc_pkg::matrix_e             matrix_type_i,
  input  logic [dmcc_pkg::PCW-1:0]      pseudocount_i,
  input  logic signed [31:0]            value_i [4],
  input  logic [dmcc_pkg::XW-1:0]       exp_i [4],
  input  logic [dmcc_pkg::XW+1:0]       exp_sum_i,
  input  logic signed [33:0]            sum_i,
  input  logic signed [34:0]            sum_pc_i,
  output dmcc_pkg::frac_t               frac_o
);
  import dmcc_pkg::*;

  localparam int HW = FRAC_BITS + 10;
  localparam logic signed [NW-1:0] One    = NW'(1) << FRAC_BITS;
  localparam logic [XW+1:0]        WinCap = (XW+2)'(8) << FRAC_BITS;
  localparam logic [HW-1:0]        Lo1    = HW'(99)  << FRAC_BITS;
  localparam logic [HW-1:0]        Hi1    = HW'(101) << FRAC_BITS;
  localparam logic [HW-1:0]        Lo4    = HW'(396) << FRAC_BITS;
  localparam logic [HW-1:0]        Hi4    = HW'(404) << FRAC_BITS;

  logic [HW-1:0]          hund;
  logic                   near1;
  logic                   near4;
  logic signed [NW-1:0]   num [4];
  logic signed [NW-1:0]   den;
  frac_t                  frac_d;

  assign hund  = HW'(exp_sum_i[FRAC_BITS+2:0]) * HW'(100);
  assign near1 = (exp_sum_i < WinCap) && (hund > Lo1) && (hund < Hi1);
  assign near4 = (exp_sum_i < WinCap) && (hund > Lo4) && (hund < Hi4);

  always_comb begin
    for (int i = 0; i < 4; i++) num[i] = NW'(value_i[i]);
    den = NW'(sum_i);
    unique case (matrix_type_i)
      MT_COUNTS: begin
        if (pseudocount_i != '0) begin
          for (int i = 0; i < 4; i++) begin
            num[i] = (NW'(value_i[i]) <<< 2) + $signed(NW'(pseudocount_i));
          end
          den = NW'(sum_pc_i) <<< 2;
        end
      end
      MT_PROB: den = One;
      MT_LOG2ODDS: begin
        for (int i = 0; i < 4; i++) num[i] = $signed(NW'(exp_i[i]));
        if (near1) begin
          den = One;
        end else if (near4) begin
          den = One <<< 2;
        end else begin
          den = $signed(NW'(exp_sum_i));
        end
      end
      MT_INFO: ;
      default: ;
    endcase

    frac_d.zero = (den == '0);
    // keep the quotient sign with a positive denominator
    if (den < 0) begin
      for (int i = 0; i < 4; i++) frac_d.num[i] = -num[i];
      frac_d.den = -den;
    end else begin
      for (int i = 0; i < 4; i++) frac_d.num[i] = num[i];
      frac_d.den = den;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) frac_o <= frac_d;
  end

endmodule

FILE: sv/dmcc_pick.sv
module dmcc_pick (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              rna_mode_i,
  input  dmcc_pkg::frac_t   frac_i,
  output logic [3:0]        letter_o
);
  import dmcc_pkg::*;

  logic signed [NW-1:0] p [4];
  logic signed [NW-1:0] d;
  logic signed [NW-1:0] d3;
  logic [3:0]           gh;
  logic [3:0]           lq;
  logic [3:0]           gq;
  logic [5:0]           pr;
  letter_e              letter_d;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      p[i]  = $signed(frac_i.num[i]);
    end
    d  = $signed(frac_i.den);
    d3 = (d <<< 1) + d;
    for (int i = 0; i < 4; i++) begin
      gh[i] = (p[i] <<< 1) > d;
      lq[i] = (p[i] <<< 2) <= d;
      gq[i] = (p[i] <<< 2) > d;
    end
    pr[0] = ((p[0] + p[1]) <<< 2) > d3;
    pr[1] = ((p[0] + p[2]) <<< 2) > d3;
    pr[2] = ((p[0] + p[3]) <<< 2) > d3;
    pr[3] = ((p[1] + p[2]) <<< 2) > d3;
    pr[4] = ((p[1] + p[3]) <<< 2) > d3;
    pr[5] = ((p[2] + p[3]) <<< 2) > d3;

    priority if (frac_i.zero)                   letter_d = LTR_N;
    else if (gh[0] && lq[1] && lq[2] && lq[3])  letter_d = LTR_A;
    else if (gh[1] && lq[0] && lq[2] && lq[3])  letter_d = LTR_C;
    else if (gh[2] && lq[0] && lq[1] && lq[3])  letter_d = LTR_G;
    else if (gh[3] && lq[0] && lq[1] && lq[2])  letter_d = rna_mode_i ? LTR_U : LTR_T;
    else if (pr[0])                             letter_d = LTR_M;
    else if (pr[1])                             letter_d = LTR_R;
    else if (pr[2])                             letter_d = LTR_W;
    else if (pr[3])                             letter_d = LTR_S;
    else if (pr[4])                             letter_d = LTR_Y;
    else if (pr[5])                             letter_d = LTR_K;
    else if (gq[0] && gq[1] && gq[3])           letter_d = LTR_H;
    else if (gq[1] && gq[2] && gq[3])           letter_d = LTR_B;
    else if (gq[0] && gq[1] && gq[2])           letter_d = LTR_V;
    else if (gq[0] && gq[2] && gq[3])           letter_d = LTR_D;
    else                                        letter_d = LTR_N;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) letter_o <= letter_d;
  end

endmodule

FILE: sv/dna_motif_column_consensus_unit.sv
// Consensus letter unit for motif columns.
// Input channel: one word per column, four signed fixed-point values
// (A, C, G, T/U) on in_valid_i / in_ready_o. Output channel: one 4-bit
// letter code per column on out_valid_o / out_ready_i, in input order.
// Configuration channel: cfg_valid_i / cfg_ready_o with cfg_index_i and
// cfg_data_i; always ready; write only while no column is in flight.
// Throughput: one column per cycle, unless a stall on out_ready_i has
// filled every stage.
// The pipeline depth comes from the exp2 mantissa chain: one constant-root multiply
// stage per fraction bit in each of the four lanes, then shift, sum,
// normalize and letter stages.
// Reset clears all valid bits and loads the register defaults
// (probabilities, DNA letters, pseudocount 1.0).
// A stall on out_ready_i holds the output word; upstream stages keep
// filling bubbles and in_ready_o drops only when every stage is full.
module dna_motif_column_consensus_unit #(
  parameter int FRAC_BITS = dmcc_pkg::FracBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [31:0]         value_a_i,
  input  logic signed [31:0]         value_c_i,
  input  logic signed [31:0]         value_g_i,
  input  logic signed [31:0]         value_t_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [3:0]                 letter_code_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [dmcc_pkg::PCW-1:0]   cfg_data_i
);
  import dmcc_pkg::*;

  localparam int NS      = FRAC_BITS + 5;
  localparam int StShift = FRAC_BITS + 1;
  localparam int StSum   = FRAC_BITS + 2;
  localparam int StNorm  = FRAC_BITS + 3;
  localparam int StOut   = FRAC_BITS + 4;

  matrix_e           matrix_type_q;
  logic              rna_mode_q;
  logic [PCW-1:0]    pseudocount_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_type_q <= MT_PROB;
      rna_mode_q    <= 1'b0;
      pseudocount_q <= PCW'(1) << FRAC_BITS;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MATRIX_TYPE: matrix_type_q <= matrix_e'(cfg_data_i[1:0]);
        CFG_RNA_MODE:    rna_mode_q    <= cfg_data_i[0];
        CFG_PSEUDOCOUNT: pseudocount_q <= cfg_data_i;
        CFG_UNUSED:      ;
        default:         ;
      endcase
    end
  end

  // Valid chain: a stage loads when it is empty or the next one loads
  logic [NS-1:0] vld_q;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) en[k] = !vld_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[StOut];

  logic signed [31:0] in_v_q [4];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      in_v_q[0] <= value_a_i;
      in_v_q[1] <= value_c_i;
      in_v_q[2] <= value_g_i;
      in_v_q[3] <= value_t_i;
    end
  end

  logic signed [31:0] lane_v [4];
  logic [XW-1:0]      lane_x [4];

  for (genvar i = 0; i < 4; i++) begin : g_lane
    dmcc_exp_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .en_i    (en[StShift:1]),
      .value_i (in_v_q[i]),
      .value_o (lane_v[i]),
      .exp_o   (lane_x[i])
    );
  end

  logic signed [31:0] sum_v_q [4];
  logic [XW-1:0]      sum_x_q [4];
  logic [XW+1:0]      exp_sum_q;
  logic signed [33:0] sum_q;
  logic signed [34:0] sum_pc_q;
  logic signed [33:0] sum_d;

  assign sum_d = 34'(lane_v[0]) + 34'(lane_v[1]) + 34'(lane_v[2]) + 34'(lane_v[3]);

  always_ff @(posedge clk_i) begin
    if (en[StSum]) begin
      sum_v_q   <= lane_v;
      sum_x_q   <= lane_x;
      exp_sum_q <= (XW+2)'(lane_x[0]) + (XW+2)'(lane_x[1])
                 + (XW+2)'(lane_x[2]) + (XW+2)'(lane_x[3]);
      sum_q     <= sum_d;
      sum_pc_q  <= 35'(sum_d) + $signed(35'(pseudocount_q));
    end
  end

  frac_t frac;

  dmcc_norm #(
    .FRAC_BITS (FRAC_BITS)
  ) u_norm (
    .clk_i         (clk_i),
    .en_i          (en[StNorm]),
    .matrix_type_i (matrix_type_q),
    .pseudocount_i (pseudocount_q),
    .value_i       (sum_v_q),
    .exp_i         (sum_x_q),
    .exp_sum_i     (exp_sum_q),
    .sum_i         (sum_q),
    .sum_pc_i      (sum_pc_q),
    .frac_o        (frac)
  );

  dmcc_pick u_pick (
    .clk_i      (clk_i),
    .en_i       (en[StOut]),
    .rna_mode_i (rna_mode_q),
    .frac_i     (frac),
    .letter_o   (letter_code_o)
  );

endmodule

FILE: sv/dmcc_checker.sv
module dmcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [3:0]  letter_code_o
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // With no word waiting at the output nothing can block the input
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output stage");

  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while the output drains");

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(letter_code_o))
    else $error("stalled output word changed");

endmodule

bind dna_motif_column_consensus_unit dmcc_checker u_dmcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .letter_code_o (letter_code_o)
);
